// ===== hw/rtl/cbse_pkg.sv =====
// ----------------------------------------------------------------------------
// cbse_pkg: shared definitions for the cardinal B-spline evaluator
// Widths, fixed-point formats, the reciprocal table, the controller states,
// the datapath commands and the datapath status bundle.
// ----------------------------------------------------------------------------
package cbse_pkg;

  localparam int MAX_ORDER     = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int WORK_FRAC     = 30;
  localparam int RECIP_FRAC    = 26;
  localparam int OUT_FRAC      = 24;

  localparam int POS_W       = 21;
  localparam int ORDER_W     = 5;
  localparam int VALUE_W     = 25;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int D_W    = $clog2(MAX_ORDER + 1);
  localparam int J_W    = $clog2(MAX_ORDER);
  localparam int T_W    = D_W + POS_FRAC_BITS;
  localparam int COEF_W = WORK_FRAC + 1;
  localparam int PROD_W = T_W + COEF_W;
  localparam int SUM_W  = PROD_W - POS_FRAC_BITS;
  localparam int RC_W   = RECIP_FRAC + 1;
  localparam int PR_W   = SUM_W + RC_W;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);

  typedef logic [RC_W-1:0] recip_t;

  // Rounded reciprocals round(2^26 / m), indexed by m; entry zero is unused.
  localparam recip_t RECIP_TABLE [MAX_ORDER] = '{
    RC_W'(0),        RC_W'(67108864), RC_W'(33554432), RC_W'(22369621),
    RC_W'(16777216), RC_W'(13421773), RC_W'(11184811), RC_W'(9586981),
    RC_W'(8388608),  RC_W'(7456540),  RC_W'(6710886),  RC_W'(6100806),
    RC_W'(5592405),  RC_W'(5162220),  RC_W'(4793490),  RC_W'(4473924)
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_MUL_L,
    ST_MUL_R,
    ST_SUM,
    ST_REC,
    ST_WRITE,
    ST_FIN_RD,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SEED,
    CMD_READ,
    CMD_MUL_L,
    CMD_MUL_R,
    CMD_SUM,
    CMD_REC,
    CMD_WRITE,
    CMD_FIN_RD,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic skip;
    logic order_one;
    logic last_j;
    logic last_d;
  } dp_status_t;

endpackage

// ===== hw/rtl/cardinal_bspline_eval.sv =====
// ----------------------------------------------------------------------------
// cardinal_bspline_eval: cardinal B-spline value at a fixed-point position
// Top level: a sequencer and a datapath that run the de Boor recurrence.
// ----------------------------------------------------------------------------
// Each item carries a position x (16 fraction bits) and returns M_k(x), the
// cardinal B-spline of order k with knots 0..k, as a value with 24 fraction
// bits. The order comes from the configuration channel (reset value 4, values
// above 16 act as 16). One item is worked on at a time. A position outside
// the open support (0, k) skips the recurrence and goes from the check
// straight to the output register; otherwise every recurrence step makes
// two passes
// through the weight multiplier and one through the reciprocal multiplier,
// each followed by a register. The input opens again when the result is
// loaded into the output register, and it stays closed while a finished
// item waits for a stalled result to leave the output register. A finished
// item waits in the output register while the next one is accepted.
module cardinal_bspline_eval (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write: spline_order.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cbse_pkg::ORDER_W-1:0]       cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: position [20:0], zero padding.
  input  logic [cbse_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: spline_value [24:0], zero padding.
  output logic [cbse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import cbse_pkg::*;

  cmd_e               cmd;
  dp_status_t         status;
  logic [VALUE_W-1:0] value;

  cbse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbse_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .pos_i       (s_axis_tdata[POS_W-1:0]),
    .value_o     (value)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {{(OUT_TDATA_W-VALUE_W){1'b0}}, value};

endmodule

// ===== hw/rtl/cbse_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbse_ctrl: sequencer for the cardinal B-spline evaluator
// Steps the datapath through load, seed, the recurrence steps and the final
// read, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module cbse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cbse_pkg::dp_status_t status_i,
  output cbse_pkg::cmd_e       cmd_o
);
  import cbse_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.skip) begin
          state_d = ST_FIN;
        end else begin
          cmd_o   = CMD_SEED;
          state_d = status_i.order_one ? ST_FIN_RD : ST_READ;
        end
      end
      ST_READ: begin
        cmd_o   = CMD_READ;
        state_d = ST_MUL_L;
      end
      ST_MUL_L: begin
        cmd_o   = CMD_MUL_L;
        state_d = ST_MUL_R;
      end
      ST_MUL_R: begin
        cmd_o   = CMD_MUL_R;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o   = CMD_SUM;
        state_d = ST_REC;
      end
      ST_REC: begin
        cmd_o   = CMD_REC;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o   = CMD_WRITE;
        state_d = (status_i.last_j && status_i.last_d) ? ST_FIN_RD : ST_READ;
      end
      ST_FIN_RD: begin
        cmd_o   = CMD_FIN_RD;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o   = CMD_OUT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o == CMD_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/cbse_datapath.sv =====
// ----------------------------------------------------------------------------
// cbse_datapath: arithmetic and storage of the cardinal B-spline evaluator
// Holds the order register, the coefficient memory, the weight multiplier,
// the reciprocal multiplier and the result register.
// ----------------------------------------------------------------------------
module cbse_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cbse_pkg::cmd_e                 cmd_i,
  output cbse_pkg::dp_status_t           status_o,
  input  logic                           cfg_valid_i,
  input  logic [cbse_pkg::ORDER_W-1:0]   cfg_data_i,
  input  logic [cbse_pkg::POS_W-1:0]     pos_i,
  output logic [cbse_pkg::VALUE_W-1:0]   value_o
);
  import cbse_pkg::*;

  localparam int CMP_W = POS_W + T_W;
  localparam int TW2   = POS_W + 2;
  localparam int VS_W  = PR_W - RECIP_FRAC;
  localparam int OR_W  = COEF_W + 1;
  localparam int OS_W  = OR_W - (WORK_FRAC - OUT_FRAC);

  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << WORK_FRAC;
  localparam logic [VS_W-1:0]   VS_ONE    = VS_W'(1) << WORK_FRAC;
  localparam logic [OS_W-1:0]   OUT_ONE   = OS_W'(1) << OUT_FRAC;
  localparam logic [PROD_W-1:0] S_HALF    = PROD_W'(1) << (POS_FRAC_BITS - 1);
  localparam logic [PR_W-1:0]   V_HALF    = PR_W'(1) << (RECIP_FRAC - 1);
  localparam logic [OR_W-1:0]   O_HALF    = OR_W'(1) << (WORK_FRAC - OUT_FRAC - 1);

  logic [ORDER_W-1:0] order_q;
  logic [POS_W-1:0]   x_q;
  logic [D_W-1:0]     k_q;
  logic [D_W-1:0]     d_q;
  logic [J_W-1:0]     j_q;
  logic [T_W-1:0]     t_q;
  logic               l_en_q, r_en_q;
  logic [COEF_W-1:0]  rd_a_q, rd_b_q;
  logic [PROD_W-1:0]  p1_q, p2_q;
  logic [SUM_W-1:0]   s_q;
  logic [PR_W-1:0]    pr_q;
  logic [VALUE_W-1:0] value_q;

  logic [COEF_W-1:0]  coef_mem [MAX_ORDER];

  logic [D_W-1:0]     k_eff;
  logic [POS_W-1:0]   xm1;
  logic [J_W-1:0]     r_idx;
  logic [T_W-1:0]     k_full, d_full;
  logic [D_W:0]       rj1;
  logic [TW2-1:0]     t_raw;
  logic [T_W-1:0]     t_new, w;
  logic [COEF_W-1:0]  left, right;
  logic [T_W-1:0]     mul_w;
  logic [COEF_W-1:0]  mul_c;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]  sum_rnd;
  logic [PR_W-1:0]    v_rnd;
  logic [VS_W-1:0]    v_sh;
  logic [COEF_W-1:0]  v_new;
  logic [J_W-1:0]     fin_addr, addr_a;
  logic [OR_W-1:0]    o_rnd;
  logic [OS_W-1:0]    o_sh;
  logic [VALUE_W-1:0] o_val;
  recip_t             rc;

  assign k_eff = (order_q > ORDER_W'(MAX_ORDER)) ? D_W'(MAX_ORDER) : D_W'(order_q);

  assign xm1    = x_q - POS_W'(1);
  assign r_idx  = xm1[POS_FRAC_BITS +: J_W];
  assign k_full = {k_q, {POS_FRAC_BITS{1'b0}}};
  assign d_full = {d_q, {POS_FRAC_BITS{1'b0}}};

  assign rj1   = (D_W+1)'(r_idx) + (D_W+1)'(j_q) + (D_W+1)'(1);
  assign t_raw = TW2'(x_q) + TW2'(d_full) - TW2'({rj1, {POS_FRAC_BITS{1'b0}}});
  assign t_new = (t_raw > TW2'(d_full)) ? d_full : t_raw[T_W-1:0];
  assign w     = d_full - t_q;

  assign left  = l_en_q ? rd_a_q : '0;
  assign right = r_en_q ? rd_b_q : '0;

  assign mul_w = (cmd_i == CMD_MUL_L) ? t_q : w;
  assign mul_c = (cmd_i == CMD_MUL_L) ? left : right;
  assign mul_p = PROD_W'(mul_w) * PROD_W'(mul_c);

  assign sum_rnd = p1_q + p2_q + S_HALF;
  assign rc      = RECIP_TABLE[J_W'(d_q - D_W'(1))];
  assign v_rnd   = pr_q + V_HALF;
  assign v_sh    = v_rnd[PR_W-1:RECIP_FRAC];
  assign v_new   = (v_sh > VS_ONE) ? COEF_ONE : v_sh[COEF_W-1:0];

  assign fin_addr = J_W'(k_q) - J_W'(1) - r_idx;
  assign addr_a   = (cmd_i == CMD_FIN_RD) ? fin_addr : (j_q - J_W'(1));

  assign o_rnd = OR_W'(rd_a_q) + O_HALF;
  assign o_sh  = o_rnd[OR_W-1:WORK_FRAC-OUT_FRAC];
  assign o_val = (o_sh > OUT_ONE) ? VALUE_W'(OUT_ONE) : VALUE_W'(o_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
      d_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        order_q <= cfg_data_i;
      end
      if (cmd_i == CMD_SEED) begin
        d_q <= D_W'(2);
        j_q <= J_W'(1);
      end else if (cmd_i == CMD_WRITE) begin
        if (j_q == '0) begin
          d_q <= d_q + D_W'(1);
          j_q <= d_q[J_W-1:0];
        end else begin
          j_q <= j_q - J_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      x_q <= pos_i;
      k_q <= k_eff;
    end
    if (cmd_i == CMD_READ) begin
      t_q    <= t_new;
      l_en_q <= (j_q != '0);
      r_en_q <= ((D_W'(j_q) + D_W'(1)) < d_q);
    end
    if (cmd_i == CMD_MUL_L) begin
      p1_q <= mul_p;
    end
    if (cmd_i == CMD_MUL_R) begin
      p2_q <= mul_p;
    end
    if (cmd_i == CMD_SUM) begin
      s_q <= sum_rnd[PROD_W-1:POS_FRAC_BITS];
    end
    if (cmd_i == CMD_REC) begin
      pr_q <= PR_W'(s_q) * PR_W'(rc);
    end
    if (cmd_i == CMD_OUT) begin
      value_q <= status_o.skip ? '0 : o_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_SEED) begin
      coef_mem[0] <= COEF_ONE;
    end else if (cmd_i == CMD_WRITE) begin
      coef_mem[j_q] <= v_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_READ || cmd_i == CMD_FIN_RD) begin
      rd_a_q <= coef_mem[addr_a];
    end
    if (cmd_i == CMD_READ) begin
      rd_b_q <= coef_mem[j_q];
    end
  end

  assign status_o.skip      = (k_q == '0) || (x_q == '0) ||
                              (CMP_W'(x_q) >= CMP_W'(k_full));
  assign status_o.order_one = (k_q == D_W'(1));
  assign status_o.last_j    = (j_q == '0);
  assign status_o.last_d    = (d_q == k_q);

  assign value_o = value_q;

endmodule

// ===== hw/rtl/cbse_checker.sv =====
// ----------------------------------------------------------------------------
// cbse_checker: port-level checks for the cardinal B-spline evaluator
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module cbse_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [cbse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import cbse_pkg::*;

  // A stalled result keeps its valid and its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // A result never exceeds 1.0 and its padding stays zero.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[OUT_TDATA_W-1:VALUE_W] == '0) &&
                       (!m_axis_tdata[OUT_FRAC] || (m_axis_tdata[OUT_FRAC-1:0] == '0))))
    else $error("result out of range");

  // Only one item is in work: acceptance closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A new result appears only at the end of an item's work.
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an item in work");

endmodule

bind cardinal_bspline_eval cbse_checker u_cbse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
